FILE: hdl/bbf_pkg.sv
// Package for the blocked Bloom filter: constants, types, hash helpers.
// No dependencies.
package bbf_pkg;

	localparam int unsigned STORE_BYTES_DEF = 65536;
	localparam logic [31:0] BLOCK_SEED = 32'd2568;
	localparam logic [31:0] C1 = 32'hcc9e2d51;
	localparam logic [31:0] C2 = 32'h1b873593;
	localparam logic [31:0] F1 = 32'h85ebca6b;
	localparam logic [31:0] F2 = 32'hc2b2ae35;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	localparam logic [1:0] REG_BLOCKS = 2'd0;
	localparam logic [1:0] REG_BYTES  = 2'd1;
	localparam logic [1:0] REG_HASHES = 2'd2;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
		rotl32 = (x << r) | (x >> (32 - r));
	endfunction

endpackage

FILE: hdl/blocked_bloom_filter.sv
// Blocked Bloom filter top level: hash sequencer, shared multiplier, remainder unit, bit store.
// Depends on bbf_pkg.
// Insert/lookup: the block hash and each bit hash take 10 hash steps and a 32-step remainder;
// each bit hash then goes through address, read, check. Lookup stops at its first clear bit.
// Clear and unused codes answer in the cycle after acceptance; clear then sweeps the store to zero.
// One transaction at a time. Reset: the store is swept to zero, no accept; config 1024/64/7.
module blocked_bloom_filter #(
	parameter int unsigned STORE_BYTES = bbf_pkg::STORE_BYTES_DEF,
	localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [63:0] key,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        present,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import bbf_pkg::*;

	typedef enum logic [10:0] {
		S_SWEEP = 11'b00000000001,
		S_IDLE  = 11'b00000000010,
		S_HASH  = 11'b00000000100,
		S_DIV   = 11'b00000001000,
		S_BASE  = 11'b00000010000,
		S_RD    = 11'b00000100000,
		S_WAIT  = 11'b00001000000,
		S_MOD   = 11'b00010000000,
		S_ADDR  = 11'b00100000000,
		S_CHK   = 11'b01000000000,
		S_OUT   = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [16:0] blocks_q;
	logic [9:0]  bytes_q;
	logic [5:0]  hashes_q;

	logic [1:0]  op_q;
	logic [63:0] key_q;
	logic [5:0]  seed_q;
	logic [3:0]  step_q;
	logic [31:0] h_q, k_q;
	logic [31:0] rem_q, quo_src_q;
	logic [5:0]  dcnt_q;
	logic [31:0] div_q;
	logic        blk_hash_q;
	logic [AW-1:0] base_q, addr_q;
	logic [2:0]  bitsel_q;
	logic        present_q;
	logic        outv_q;
	logic [AW:0] sweep_q;

	// bit store
	logic [7:0] mem [STORE_BYTES];
	logic [7:0] rdata_q;
	logic       we;
	logic [AW-1:0] waddr;
	logic [7:0] wdata;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[addr_q];
	end

	assign in_stall  = (state_q != S_IDLE) || outv_q;
	assign out_valid = outv_q;
	assign present   = present_q;
	assign cfg_ready = 1'b1;

	logic [16:0] nblk;
	logic [9:0]  bsz;
	assign nblk = (blocks_q == 17'd0) ? 17'd1 : blocks_q;
	assign bsz  = (bytes_q == 10'd0) ? 10'd1 : bytes_q;

	// shared multiplier operand and product
	logic [31:0] ma, mb, mp;
	assign mp = ma * mb;

	always_comb begin
		ma = k_q;
		mb = C1;
		case (step_q)
			4'd0, 4'd4: begin ma = k_q; mb = C1; end
			4'd1, 4'd5: begin ma = k_q; mb = C2; end
			4'd2, 4'd6: begin ma = h_q; mb = 32'd5; end
			4'd8:       begin ma = h_q; mb = F1; end
			4'd9:       begin ma = h_q; mb = F2; end
			default:    begin ma = h_q; mb = 32'd1; end
		endcase
	end

	// remainder step: shift one dividend bit in
	logic [32:0] rtry;
	logic [31:0] rsh;
	assign rsh  = {rem_q[30:0], quo_src_q[31]};
	assign rtry = {rem_q[31], rsh} - {1'b0, div_q};

	logic [AW+9:0] base_full;
	logic [AW:0]   addr_full;
	assign base_full = (AW+10)'(rem_q[16:0]) * (AW+10)'(bsz);
	assign addr_full = (AW+1)'({1'b0, base_q}) + (AW+1)'(rem_q[31:3]);

	assign we    = (state_q == S_SWEEP) || (state_q == S_CHK && op_q == OP_INSERT);
	assign waddr = (state_q == S_SWEEP) ? sweep_q[AW-1:0] : addr_q;
	assign wdata = (state_q == S_SWEEP) ? 8'd0 : (rdata_q | (8'h80 >> bitsel_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_SWEEP;
			blocks_q <= 17'd1024;
			bytes_q  <= 10'd64;
			hashes_q <= 6'd7;
			sweep_q  <= '0;
			outv_q   <= 1'b0;
		end else begin
			// configuration
			if (cfg_valid) begin
				case (cfg_index)
					REG_BLOCKS: blocks_q <= cfg_data[16:0];
					REG_BYTES:  bytes_q  <= cfg_data[9:0];
					REG_HASHES: hashes_q <= cfg_data[5:0];
					default: ;
				endcase
			end
			if (outv_q && !out_stall)
				outv_q <= 1'b0;
			unique case (state_q)
				S_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == (AW+1)'(STORE_BYTES - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						op_q  <= operation;
						key_q <= key;
						present_q <= (operation == OP_INSERT) || (operation == OP_LOOKUP);
						sweep_q <= '0;
						if (operation == OP_CLEAR) begin
							state_q <= S_SWEEP;
							outv_q  <= 1'b1;
						end else if (operation == OP_NONE) begin
							outv_q <= 1'b1;
						end else begin
							blk_hash_q <= 1'b1;
							h_q    <= BLOCK_SEED;
							k_q    <= key[31:0];
							step_q <= '0;
							seed_q <= '0;
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					step_q <= step_q + 1'b1;
					case (step_q)
						// rotation of k precedes its second multiply
						4'd0, 4'd4: k_q <= rotl32(mp, 15);
						4'd1, 4'd5: begin
							k_q <= mp;
							h_q <= rotl32(h_q ^ mp, 13);
						end
						4'd2: begin
							h_q <= mp + 32'he6546b64;
							k_q <= key_q[63:32];
						end
						4'd6: h_q <= mp + 32'he6546b64;
						4'd7: h_q <= (h_q ^ 32'd8) ^ ((h_q ^ 32'd8) >> 16);
						4'd8: h_q <= mp ^ (mp >> 13);
						4'd9: begin
							h_q <= mp ^ (mp >> 16);
							quo_src_q <= mp ^ (mp >> 16);
							rem_q  <= '0;
							dcnt_q <= '0;
							div_q  <= blk_hash_q ? {15'd0, nblk} : {19'd0, bsz, 3'd0};
							state_q <= blk_hash_q ? S_DIV : S_MOD;
						end
						default: ;
					endcase
				end
				S_DIV, S_MOD: begin
					quo_src_q <= {quo_src_q[30:0], 1'b0};
					rem_q <= rtry[32] ? rsh : rtry[31:0];
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == 6'd31)
						state_q <= (state_q == S_DIV) ? S_BASE : S_ADDR;
				end
				S_BASE: begin
					base_q <= base_full[AW-1:0];
					blk_hash_q <= 1'b0;
					state_q <= S_RD;
				end
				S_RD: begin
					if (seed_q >= hashes_q) begin
						state_q <= S_OUT;
					end else begin
						h_q <= {26'd0, seed_q};
						k_q <= key_q[31:0];
						step_q <= '0;
						state_q <= S_HASH;
					end
				end
				S_ADDR: begin
					addr_q   <= addr_full[AW-1:0];
					bitsel_q <= rem_q[2:0];
					state_q  <= S_WAIT;
				end
				S_WAIT: state_q <= S_CHK;
				S_CHK: begin
					seed_q <= seed_q + 1'b1;
					if (op_q == OP_LOOKUP && !rdata_q[3'd7 - bitsel_q]) begin
						present_q <= 1'b0;
						state_q <= S_OUT;
					end else begin
						state_q <= S_RD;
					end
				end
				S_OUT: begin
					outv_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// never write the store outside sweep or check
	a_we: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == S_SWEEP || state_q == S_CHK)) else $error("bad write");
	// no new result while one waits
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(outv_q && out_stall) |=> outv_q) else $error("result lost");
	// no item taken during the sweep
	a_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP) |-> in_stall) else $error("accept during sweep");
`endif

endmodule

FILE: bench/tb_blocked_bloom_filter.sv
// Self-checking testbench for blocked_bloom_filter: directed and random insert/lookup/clear
// traffic under random stalls, checked against a behavioral predictor. Depends on bbf_pkg.
`timescale 1ns / 100ps

module tb_blocked_bloom_filter;
	import bbf_pkg::*;

	localparam int unsigned NBYTES = 65536;
	localparam int SETTLE_CYCLES = 400;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  operation;
	logic [63:0] key;
	logic        out_valid;
	logic        out_stall;
	logic        present;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	// predictor state
	logic [7:0]  filt_bytes [NBYTES];
	logic [16:0] cur_blocks;
	logic [9:0]  cur_bytes;
	logic [5:0]  cur_hashes;
	logic        present_q [$];
	logic [63:0] inserted_keys [$];
	int          fail_count;
	bit          quiet;

	blocked_bloom_filter u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation), .key(key),
		.out_valid(out_valid), .out_stall(out_stall), .present(present),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(64'd12 * 64'd30_000_000);
		$display("TB_ERROR");
		$finish;
	end

	// one MurmurHash3 x86_32 block round
	function automatic logic [31:0] murmur_round(input logic [31:0] h, input logic [31:0] k);
		logic [31:0] t;
		logic [31:0] s;
		t = k * 32'hcc9e2d51;
		t = {t[16:0], t[31:17]};
		t = t * 32'h1b873593;
		s = h ^ t;
		s = {s[18:0], s[31:19]};
		return s * 32'd5 + 32'he6546b64;
	endfunction

	function automatic logic [31:0] key_hash(input logic [63:0] k, input logic [31:0] seed);
		logic [31:0] h;
		h = murmur_round(seed, k[31:0]);
		h = murmur_round(h, k[63:32]);
		h = h ^ 32'd8;
		h = h ^ (h >> 16);
		h = h * 32'h85ebca6b;
		h = h ^ (h >> 13);
		h = h * 32'hc2b2ae35;
		h = h ^ (h >> 16);
		return h;
	endfunction

	// applies one transaction to the filter image and returns the expected answer
	function automatic logic filter_answer(input logic [1:0] op, input logic [63:0] k);
		logic [31:0] nblk;
		logic [31:0] bsz;
		logic [31:0] nbits;
		logic [31:0] base;
		logic [31:0] bitpos;
		logic [31:0] addr;
		logic [7:0]  mask;
		logic        hit;
		hit = 1'b1;
		if (op == OP_CLEAR) begin
			for (int j = 0; j < NBYTES; j++) filt_bytes[j] = 8'h00;
			return 1'b0;
		end
		if (op == OP_NONE) return 1'b0;
		nblk = (cur_blocks == 0) ? 32'd1 : 32'(cur_blocks);
		bsz = (cur_bytes == 0) ? 32'd1 : 32'(cur_bytes);
		nbits = bsz * 32'd8;
		base = (key_hash(k, BLOCK_SEED) % nblk) * bsz;
		for (int s = 0; s < cur_hashes; s++) begin
			bitpos = key_hash(k, 32'(s)) % nbits;
			addr = (base + (bitpos >> 3)) % NBYTES;
			mask = 8'h80 >> bitpos[2:0];
			if (op == OP_INSERT) begin
				filt_bytes[addr[15:0]] = filt_bytes[addr[15:0]] | mask;
			end else if ((filt_bytes[addr[15:0]] & mask) == 8'h00) begin
				hit = 1'b0;
				break;
			end
		end
		return hit;
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// input driver: one transaction, optional idle cycles before it
	task automatic send_item(input logic [1:0] op, input logic [63:0] k);
		int gap;
		bit done;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		key <= k;
		done = 0;
		while (!done) begin
			@(negedge clk);
			done = !in_stall;
			@(posedge clk);
		end
		present_q.push_back(filter_answer(op, k));
		if (op == OP_INSERT) inserted_keys.push_back(k);
		if (op == OP_CLEAR) inserted_keys.delete();
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (present_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register write; the caller drops cfg_valid after its last write
	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
		bit done;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		done = 0;
		while (!done) begin
			@(negedge clk);
			done = cfg_ready;
			@(posedge clk);
		end
		case (idx)
			REG_BLOCKS: cur_blocks = data[16:0];
			REG_BYTES:  cur_bytes = data[9:0];
			REG_HASHES: cur_hashes = data[5:0];
			default: ;
		endcase
	endtask

	task automatic set_geometry(input logic [31:0] nblk, input logic [31:0] bsz,
			input logic [31:0] nh);
		wait_drained();
		cfg_write(REG_BLOCKS, nblk);
		cfg_write(REG_BYTES, bsz);
		cfg_write(REG_HASHES, nh);
		cfg_valid <= 1'b0;
	endtask

	// result checker with random back-pressure
	initial begin : result_check
		int hold;
		int r;
		logic exp_present;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (out_valid && !out_stall) begin
				if (present_q.size() == 0) begin
					$error("unexpected result: present=%0b", present);
					fail_count++;
				end else begin
					exp_present = present_q.pop_front();
					if (present !== exp_present) begin
						$error("present mismatch: expected %0b actual %0b", exp_present, present);
						fail_count++;
					end
				end
			end
			@(posedge clk);
			if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
			end else begin
				out_stall <= 1'b0;
				if (!quiet) begin
					r = $urandom_range(0, 99);
					if (r < 25) hold = $urandom_range(1, 3);
					else if (r < 28) hold = $urandom_range(20, 150);
				end
			end
		end
	end

	// defaults after reset: empty filter, extreme keys, unused opcode
	task automatic test_defaults();
		send_item(OP_LOOKUP, 64'h0);
		send_item(OP_INSERT, 64'h0);
		send_item(OP_LOOKUP, 64'h0);
		send_item(OP_LOOKUP, 64'hffff_ffff_ffff_ffff);
		send_item(OP_INSERT, 64'hffff_ffff_ffff_ffff);
		send_item(OP_LOOKUP, 64'hffff_ffff_ffff_ffff);
		send_item(OP_NONE, 64'h0123_4567_89ab_cdef);
		send_item(OP_LOOKUP, 64'h0);
	endtask

	// register extremes: zero hashes, 32 hashes, tiny filter, overrun, zero sizes
	task automatic test_geometry_edges();
		set_geometry(32'd8, 32'd4, 32'd0);
		send_item(OP_LOOKUP, 64'h5555_aaaa_5555_aaaa);
		send_item(OP_INSERT, 64'h5555_aaaa_5555_aaaa);
		set_geometry(32'd1, 32'd1, 32'd32);
		send_item(OP_LOOKUP, 64'h1);
		send_item(OP_INSERT, 64'h1);
		send_item(OP_LOOKUP, 64'h2);
		set_geometry(32'd65536, 32'd512, 32'd3);
		send_item(OP_INSERT, 64'hdead_beef_cafe_f00d);
		send_item(OP_LOOKUP, 64'hdead_beef_cafe_f00d);
		send_item(OP_LOOKUP, 64'h8000_0000_0000_0000);
		set_geometry(32'd0, 32'd0, 32'd2);
		send_item(OP_INSERT, 64'h7);
		send_item(OP_LOOKUP, 64'h8);
		send_item(OP_CLEAR, 64'h0);
		send_item(OP_LOOKUP, 64'h7);
	endtask

	task automatic random_phase(input int count, input int clears);
		int r;
		int c;
		logic [63:0] k;
		c = clears;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 999);
			k = {$urandom(), $urandom()};
			if (c > 0 && n == count / 2) begin
				send_item(OP_CLEAR, k);
				c--;
			end else if (r < 450) begin
				send_item(OP_INSERT, k);
			end else if (r < 700 && inserted_keys.size() > 0) begin
				send_item(OP_LOOKUP, inserted_keys[$urandom_range(0, inserted_keys.size() - 1)]);
			end else if (r < 970) begin
				send_item(OP_LOOKUP, k);
			end else begin
				send_item(OP_NONE, k);
			end
		end
	endtask

	task automatic test_random();
		set_geometry(32'd1024, 32'd64, 32'd7);
		random_phase(350, 1);
		set_geometry(32'd1, 32'd1, 32'd3);
		random_phase(200, 0);
		quiet = 1;
		set_geometry(32'd16, 32'd8, 32'd2);
		random_phase(300, 0);
		quiet = 0;
		set_geometry(32'd65536, 32'd1, 32'd4);
		random_phase(350, 0);
		set_geometry(32'd200, 32'd512, 32'd1);
		random_phase(300, 1);
		set_geometry(32'd7, 32'd3, 32'd32);
		random_phase(60, 0);
		set_geometry(32'h0001_ffff, 32'h3ff, 32'h3f);
		random_phase(40, 0);
		set_geometry(32'd300, 32'd16, 32'd5);
		random_phase(330, 0);
	endtask

	initial begin
		fail_count = 0;
		quiet = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_INSERT;
		key = 64'h0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_BLOCKS;
		cfg_data = 32'h0;
		for (int j = 0; j < NBYTES; j++) filt_bytes[j] = 8'h00;
		cur_blocks = 17'd1024;
		cur_bytes = 10'd64;
		cur_hashes = 6'd7;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_geometry_edges();
		test_random();
		wait_drained();
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
